### hw/rtl/c3zp_pkg.sv
// ----------------------------------------------------------------------------
// c3zp_pkg
// Shared sizes, types and register indexes of the 3x3 zero-padded filter.
// ----------------------------------------------------------------------------
package c3zp_pkg;

  localparam int MAX_WIDTH  = 1024;
  localparam int MAX_HEIGHT = 1024;
  localparam int PIXEL_BITS = 8;
  localparam int COEF_BITS  = 16;

  localparam int ADDR_W    = $clog2(MAX_WIDTH);
  localparam int DIM_W     = 11;               // image_width / image_height registers
  localparam int ROW_W     = 10;               // emitted row index
  localparam int CNT_W     = ADDR_W + 1;       // column counters must hold MAX_WIDTH
  localparam int CFG_W     = 3 * COEF_BITS;
  localparam int CFG_IDX_W = 3;
  localparam int PROD_W    = PIXEL_BITS + 1 + COEF_BITS;
  localparam int CSUM_W    = PROD_W + 2;
  localparam int TOT_W     = CSUM_W + 2;
  localparam int SUM_W     = 28;

  localparam logic [CFG_IDX_W-1:0] REG_COEF_TOP = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_COEF_MID = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_COEF_BOT = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_WIDTH    = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_HEIGHT   = 3'd4;

  typedef logic [PIXEL_BITS-1:0]       pix_t;
  typedef logic signed [COEF_BITS-1:0] coef_t;
  typedef pix_t  [2:0]                 pix_col_t;   // index 0 is the top row
  typedef coef_t [2:0]                 coef_col_t;  // index 0 is the top row
  typedef logic [ADDR_W-1:0]           addr_t;

  typedef struct packed {
    pix_t upper;
    pix_t lower;
  } ls_entry_t;

  typedef struct packed {
    logic adv;       // pipeline advances this cycle
    logic shift;     // a new column enters the window
    logic kill_col;  // whole column lies outside the frame
    logic kill_top;  // top row lies outside the frame
    logic kill_bot;  // bottom row lies outside the frame
  } cell_ctl_t;

endpackage

### hw/rtl/c3zp_line_store.sv
// ----------------------------------------------------------------------------
// c3zp_line_store
// Two line buffers held as one memory of {upper, lower} pixel pairs, with a
// registered read and forwarding of a write to the same column.
// ----------------------------------------------------------------------------
module c3zp_line_store (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               rd_en,
  input  c3zp_pkg::addr_t    rd_addr,
  input  logic               wr_en,
  input  c3zp_pkg::addr_t    wr_addr,
  input  c3zp_pkg::ls_entry_t wr_data,
  output c3zp_pkg::ls_entry_t rd_data
);
  import c3zp_pkg::*;

  ls_entry_t mem [MAX_WIDTH];
  ls_entry_t rd_r;
  ls_entry_t fwd_r;
  logic      fwd_hit_r;

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_r  <= mem[rd_addr];
      fwd_r <= wr_data;
    end
  end

  // A one-pixel-wide frame reads the column that is written in the same cycle.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      fwd_hit_r <= 1'b0;
    end else if (rd_en) begin
      fwd_hit_r <= wr_en && (wr_addr == rd_addr);
    end
  end

  assign rd_data = fwd_hit_r ? fwd_r : rd_r;

endmodule

### hw/rtl/c3zp_cell.sv
// ----------------------------------------------------------------------------
// c3zp_cell
// One column of the 3x3 window: holds three pixels, passes them to its left
// neighbor on each shift, and forms the weighted sum of its column.
// ----------------------------------------------------------------------------
module c3zp_cell (
  input  logic                       clk,
  input  c3zp_pkg::cell_ctl_t        ctl,
  input  c3zp_pkg::pix_col_t         col_in,
  input  c3zp_pkg::coef_col_t        weights,
  output c3zp_pkg::pix_col_t         col_out,
  output logic signed [c3zp_pkg::CSUM_W-1:0] col_sum
);
  import c3zp_pkg::*;

  pix_col_t                  pix_r;
  pix_t                      masked [3];
  logic signed [PROD_W-1:0]  prod_r [3];
  logic signed [CSUM_W-1:0]  sum_r;

  always_ff @(posedge clk) begin
    if (ctl.shift) begin
      pix_r <= col_in;
    end
  end

  always_comb begin
    masked[0] = (ctl.kill_col || ctl.kill_top) ? '0 : pix_r[0];
    masked[1] = ctl.kill_col ? '0 : pix_r[1];
    masked[2] = (ctl.kill_col || ctl.kill_bot) ? '0 : pix_r[2];
  end

  always_ff @(posedge clk) begin
    if (ctl.adv) begin
      for (int r = 0; r < 3; r++) begin
        prod_r[r] <= PROD_W'($signed({1'b0, masked[r]}) * $signed(weights[r]));
      end
      sum_r <= CSUM_W'(prod_r[0]) + CSUM_W'(prod_r[1]) + CSUM_W'(prod_r[2]);
    end
  end

  assign col_out = pix_r;
  assign col_sum = sum_r;

endmodule

### hw/rtl/conv3x3_zero_pad_filter_core.sv
// ----------------------------------------------------------------------------
// conv3x3_zero_pad_filter_core
// Streaming 3x3 convolution (correlation, no kernel flip) with zero padding.
// Pixels enter in raster order, one beat per clock while out_tready does not
// hold a result back. The result for pixel k leaves on the beat caused by input
// k+W+1, so W+1 flush beats (tuser set) drain a frame; the output beat passes
// through registers for the line-store read, the window shift, the
// multiply, the column sum and the final add. The line store is one memory of
// MAX_WIDTH pixel pairs with one read and one write per cycle; it needs no
// clearing pass, since top-border reads are masked. out_tlast marks the final
// result of a frame, after which all position counters start over. Write the
// configuration port only while no beat is in flight.
// ----------------------------------------------------------------------------
module conv3x3_zero_pad_filter_core (
  input  logic                               clk,
  input  logic                               rst_n,
  // input stream
  input  logic                               in_tvalid,
  output logic                               in_tready,
  input  logic [7:0]                         in_tdata,   // [7:0] pixel
  input  logic                               in_tuser,   // [0] func: 1 = flush tick
  // result stream
  output logic                               out_tvalid,
  input  logic                               out_tready,
  output logic [47:0]                        out_tdata,  // [27:0] sum, [37:28] out_row,
                                                         // [47:38] out_col
  output logic                               out_tlast,  // last result of the frame
  // configuration
  input  logic                               cfg_we,
  input  logic [c3zp_pkg::CFG_IDX_W-1:0]     cfg_index,
  input  logic [c3zp_pkg::CFG_W-1:0]         cfg_wdata
);
  import c3zp_pkg::*;

  // configuration registers
  logic [CFG_W-1:0] coef_top_r, coef_mid_r, coef_bot_r;
  logic [DIM_W-1:0] width_r, height_r;

  // position counters
  logic [DIM_W-1:0] in_row_r, in_row_nxt;
  logic [CNT_W-1:0] in_col_r, in_col_nxt;
  logic [ROW_W-1:0] emit_row_r, emit_row_nxt;
  logic [CNT_W-1:0] emit_col_r, emit_col_nxt;

  // stage A (accept) signals
  logic             en;
  logic             accept;
  logic [DIM_W-1:0] w, h;
  logic [DIM_W-1:0] row_a;
  logic [CNT_W-1:0] col_a;
  logic [ROW_W-1:0] erow_a;
  logic [CNT_W-1:0] ecol_a;
  pix_t             p_a;
  logic             emit_a, last_a;
  logic             kill_left_a, kill_right_a, kill_top_a, kill_bot_a;

  // stage B
  logic             b_valid_r, b_emit_r, b_up_en_r, b_lo_en_r;
  pix_t             b_p_r;
  addr_t            b_addr_r;
  logic             b_last_r;
  logic [ROW_W-1:0] b_row_r;
  logic [ROW_W-1:0] b_col_r;
  logic             b_kl_r, b_kr_r, b_kt_r, b_kb_r;
  ls_entry_t        ls_rd, ls_wr;
  pix_col_t         new_col;

  // stage C
  logic             c_valid_r, c_last_r;
  logic [ROW_W-1:0] c_row_r, c_col_r;
  logic             c_kl_r, c_kr_r, c_kt_r, c_kb_r;

  // stage D, E, output
  logic             d_valid_r, d_last_r, e_valid_r, e_last_r;
  logic [ROW_W-1:0] d_row_r, d_col_r, e_row_r, e_col_r;
  logic             out_valid_r, out_last_r;
  logic [ROW_W-1:0] out_row_r, out_col_r;
  logic [SUM_W-1:0] out_sum_r;
  logic [TOT_W-1:0] total;

  // window cells, 0 = left column
  cell_ctl_t                 ctl [3];
  pix_col_t                  col_link [3];
  coef_col_t                 wgt [3];
  logic signed [CSUM_W-1:0]  csum [3];

  // --------------------------------------------------------------------------
  // Configuration
  // --------------------------------------------------------------------------
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      coef_top_r <= '0;
      coef_mid_r <= CFG_W'(65536);
      coef_bot_r <= '0;
      width_r    <= DIM_W'(64);
      height_r   <= DIM_W'(64);
    end else if (cfg_we) begin
      case (cfg_index)
        REG_COEF_TOP: coef_top_r <= cfg_wdata;
        REG_COEF_MID: coef_mid_r <= cfg_wdata;
        REG_COEF_BOT: coef_bot_r <= cfg_wdata;
        REG_WIDTH:    width_r    <= cfg_wdata[DIM_W-1:0];
        REG_HEIGHT:   height_r   <= cfg_wdata[DIM_W-1:0];
        default: ;
      endcase
    end
  end

  // --------------------------------------------------------------------------
  // Stage A: position bookkeeping at the accepting edge
  // --------------------------------------------------------------------------
  assign en        = !out_valid_r || out_tready;
  assign in_tready = en;
  assign accept    = in_tvalid && en;

  always_comb begin
    w = (width_r == '0) ? DIM_W'(1) :
        (width_r > DIM_W'(MAX_WIDTH)) ? DIM_W'(MAX_WIDTH) : width_r;
    h = (height_r == '0) ? DIM_W'(1) :
        (height_r > DIM_W'(MAX_HEIGHT)) ? DIM_W'(MAX_HEIGHT) : height_r;

    if (in_col_r >= CNT_W'(w)) begin
      col_a = '0;
      row_a = in_row_r + DIM_W'(1);
    end else begin
      col_a = in_col_r;
      row_a = in_row_r;
    end
    if (emit_col_r >= CNT_W'(w)) begin
      ecol_a = '0;
      erow_a = emit_row_r + ROW_W'(1);
    end else begin
      ecol_a = emit_col_r;
      erow_a = emit_row_r;
    end

    p_a    = (!in_tuser && (row_a < h)) ? in_tdata : '0;
    emit_a = (row_a >= DIM_W'(2)) || ((row_a == DIM_W'(1)) && (col_a != '0));

    kill_left_a  = (ecol_a == '0);
    // At column zero the window has not seen the next pixel of the row yet.
    kill_right_a = ((ecol_a + CNT_W'(1)) >= CNT_W'(w)) || (col_a == '0);
    kill_top_a   = (erow_a == '0);
    kill_bot_a   = (({1'b0, erow_a} + DIM_W'(1)) >= h);
    last_a       = kill_bot_a && ((ecol_a + CNT_W'(1)) >= CNT_W'(w));

    if (emit_a && last_a) begin
      in_row_nxt   = '0;
      in_col_nxt   = '0;
      emit_row_nxt = '0;
      emit_col_nxt = '0;
    end else begin
      in_row_nxt   = row_a;
      in_col_nxt   = col_a + CNT_W'(1);
      emit_row_nxt = erow_a;
      emit_col_nxt = emit_a ? (ecol_a + CNT_W'(1)) : ecol_a;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_row_r   <= '0;
      in_col_r   <= '0;
      emit_row_r <= '0;
      emit_col_r <= '0;
    end else if (accept) begin
      in_row_r   <= in_row_nxt;
      in_col_r   <= in_col_nxt;
      emit_row_r <= emit_row_nxt;
      emit_col_r <= emit_col_nxt;
    end
  end

  // --------------------------------------------------------------------------
  // Stage B: line store access and window shift
  // --------------------------------------------------------------------------
  assign ls_wr = '{upper: ls_rd.lower, lower: b_p_r};

  c3zp_line_store u_line_store (
    .clk     (clk),
    .rst_n   (rst_n),
    .rd_en   (en),
    .rd_addr (col_a[ADDR_W-1:0]),
    .wr_en   (en && b_valid_r),
    .wr_addr (b_addr_r),
    .wr_data (ls_wr),
    .rd_data (ls_rd)
  );

  always_comb begin
    new_col[0] = b_up_en_r ? ls_rd.upper : '0;
    new_col[1] = b_lo_en_r ? ls_rd.lower : '0;
    new_col[2] = b_p_r;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      b_valid_r <= 1'b0;
    end else if (en) begin
      b_valid_r <= in_tvalid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      b_emit_r  <= emit_a;
      b_up_en_r <= (row_a >= DIM_W'(2));
      b_lo_en_r <= (row_a >= DIM_W'(1));
      b_p_r     <= p_a;
      b_addr_r  <= col_a[ADDR_W-1:0];
      b_last_r  <= last_a;
      b_row_r   <= erow_a;
      b_col_r   <= ecol_a[ROW_W-1:0];
      b_kl_r    <= kill_left_a;
      b_kr_r    <= kill_right_a;
      b_kt_r    <= kill_top_a;
      b_kb_r    <= kill_bot_a;
    end
  end

  // --------------------------------------------------------------------------
  // Stages C to E and output: products, column sums and the final add
  // --------------------------------------------------------------------------
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      c_valid_r   <= 1'b0;
      d_valid_r   <= 1'b0;
      e_valid_r   <= 1'b0;
      out_valid_r <= 1'b0;
    end else if (en) begin
      c_valid_r   <= b_valid_r && b_emit_r;
      d_valid_r   <= c_valid_r;
      e_valid_r   <= d_valid_r;
      out_valid_r <= e_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      c_last_r   <= b_last_r;
      c_row_r    <= b_row_r;
      c_col_r    <= b_col_r;
      c_kl_r     <= b_kl_r;
      c_kr_r     <= b_kr_r;
      c_kt_r     <= b_kt_r;
      c_kb_r     <= b_kb_r;
      d_last_r   <= c_last_r;
      d_row_r    <= c_row_r;
      d_col_r    <= c_col_r;
      e_last_r   <= d_last_r;
      e_row_r    <= d_row_r;
      e_col_r    <= d_col_r;
      out_last_r <= e_last_r;
      out_row_r  <= e_row_r;
      out_col_r  <= e_col_r;
      out_sum_r  <= total[SUM_W-1:0];
    end
  end

  always_comb begin
    for (int i = 0; i < 3; i++) begin
      ctl[i].adv      = en;
      ctl[i].shift    = en && b_valid_r;
      ctl[i].kill_top = c_kt_r;
      ctl[i].kill_bot = c_kb_r;
      wgt[i][0]       = coef_top_r[i*COEF_BITS +: COEF_BITS];
      wgt[i][1]       = coef_mid_r[i*COEF_BITS +: COEF_BITS];
      wgt[i][2]       = coef_bot_r[i*COEF_BITS +: COEF_BITS];
    end
    ctl[0].kill_col = c_kl_r;
    ctl[1].kill_col = 1'b0;
    ctl[2].kill_col = c_kr_r;
  end

  // Columns move right to left: the right cell takes the fresh column.
  c3zp_cell u_cell_left (
    .clk     (clk),
    .ctl     (ctl[0]),
    .col_in  (col_link[1]),
    .weights (wgt[0]),
    .col_out (col_link[0]),
    .col_sum (csum[0])
  );

  c3zp_cell u_cell_mid (
    .clk     (clk),
    .ctl     (ctl[1]),
    .col_in  (col_link[2]),
    .weights (wgt[1]),
    .col_out (col_link[1]),
    .col_sum (csum[1])
  );

  c3zp_cell u_cell_right (
    .clk     (clk),
    .ctl     (ctl[2]),
    .col_in  (new_col),
    .weights (wgt[2]),
    .col_out (col_link[2]),
    .col_sum (csum[2])
  );

  assign total = TOT_W'(csum[0]) + TOT_W'(csum[1]) + TOT_W'(csum[2]);

  assign out_tvalid = out_valid_r;
  assign out_tdata  = {out_col_r, out_row_r, out_sum_r};
  assign out_tlast  = out_last_r;

`ifndef SYNTHESIS
  // A frame's final result returns every position counter to the origin.
  a_frame_restart: assert property (@(posedge clk) disable iff (!rst_n)
    (accept && emit_a && last_a) |=>
      (in_row_r == '0 && in_col_r == '0 && emit_row_r == '0 && emit_col_r == '0))
    else $error("counters not cleared after the last result of a frame");

  // A held result blocks new input beats.
  a_stall_blocks_input: assert property (@(posedge clk) disable iff (!rst_n)
    (out_tvalid && !out_tready) |-> !in_tready)
    else $error("input accepted while the result beat is stalled");

  // An emitting beat in stage B moves into the product stage.
  a_emit_flows: assert property (@(posedge clk) disable iff (!rst_n)
    (en && b_valid_r && b_emit_r) |=> c_valid_r)
    else $error("emitting beat lost between window and product stage");
`endif

endmodule

### sim/conv3x3_zero_pad_filter_core_tb.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// conv3x3_zero_pad_filter_core_tb
// Streams whole frames through the filter and compares each result beat with a
// behavioral predictor of the line stores, the window and the border masking.
// Configuration changes only between frames, with both sides stalling at
// random, one long output hold-off, and a frame with an oversized height
// register at the end.
// ----------------------------------------------------------------------------
import c3zp_pkg::*;

typedef struct packed {
  logic [27:0] sum;
  logic [9:0]  row;
  logic [9:0]  col;
  logic        tlast;
} conv_sum_t;

class conv_checker;
  logic [CFG_W-1:0] coef_rows [3];
  logic [DIM_W-1:0] width_reg;
  logic [DIM_W-1:0] height_reg;
  pix_t             upper_line [MAX_WIDTH];
  pix_t             lower_line [MAX_WIDTH];
  pix_t             win [3][3];
  int               in_row, in_col, emit_row, emit_col;
  conv_sum_t        expected_sums [$];
  int               errors;

  function new();
    coef_rows[0] = '0;
    coef_rows[1] = 48'h10000;
    coef_rows[2] = '0;
    width_reg    = 11'd64;
    height_reg   = 11'd64;
    foreach (upper_line[i]) begin
      upper_line[i] = '0;
      lower_line[i] = '0;
    end
    foreach (win[r, c]) win[r][c] = '0;
    in_row   = 0;
    in_col   = 0;
    emit_row = 0;
    emit_col = 0;
    errors   = 0;
  endfunction

  function void set_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_W-1:0] val);
    case (idx)
      REG_COEF_TOP: coef_rows[0] = val;
      REG_COEF_MID: coef_rows[1] = val;
      REG_COEF_BOT: coef_rows[2] = val;
      REG_WIDTH:    width_reg    = val[DIM_W-1:0];
      REG_HEIGHT:   height_reg   = val[DIM_W-1:0];
      default: ;
    endcase
  endfunction

  function int eff_width();
    int w;
    w = int'(width_reg);
    if (w < 1) w = 1;
    if (w > MAX_WIDTH) w = MAX_WIDTH;
    return w;
  endfunction

  function int eff_height();
    int h;
    h = int'(height_reg);
    if (h < 1) h = 1;
    if (h > MAX_HEIGHT) h = MAX_HEIGHT;
    return h;
  endfunction

  function int pending();
    return expected_sums.size();
  endfunction

  // One accepted input beat: advance the line stores and the window, and
  // queue the sum of the neighbourhood whose centre becomes complete.
  function void add_pixel_beat(logic fl, pix_t px);
    int        w, h;
    pix_t      p, up, lo;
    pix_t      pre [3][2];
    pix_t      nb [3][3];
    coef_t     wt;
    longint    acc;
    bit        emit;
    conv_sum_t e;
    w = eff_width();
    h = eff_height();
    if (in_col >= w) begin
      in_col = 0;
      in_row = (in_row + 1) & 'h7FF;
    end
    if (emit_col >= w) begin
      emit_col = 0;
      emit_row = (emit_row + 1) & 'h3FF;
    end
    // Past the last row every beat supplies zero, whatever its kind.
    p  = (fl == 1'b0 && in_row < h) ? px : '0;
    up = (in_row >= 2) ? upper_line[in_col] : '0;
    lo = (in_row >= 1) ? lower_line[in_col] : '0;
    upper_line[in_col] = lower_line[in_col];
    lower_line[in_col] = p;
    emit = (in_row >= 2) || (in_row == 1 && in_col >= 1);
    for (int r = 0; r < 3; r++) begin
      pre[r][0] = win[r][1];
      pre[r][1] = win[r][2];
      win[r][0] = win[r][1];
      win[r][1] = win[r][2];
    end
    win[0][2] = up;
    win[1][2] = lo;
    win[2][2] = p;
    if (!emit) begin
      in_col++;
      return;
    end
    // At column 0 the pending centre is the last pixel of the previous row.
    for (int r = 0; r < 3; r++) begin
      if (in_col == 0) begin
        nb[r][0] = pre[r][0];
        nb[r][1] = pre[r][1];
        nb[r][2] = '0;
      end else begin
        for (int c = 0; c < 3; c++) nb[r][c] = win[r][c];
      end
    end
    in_col++;
    for (int k = 0; k < 3; k++) begin
      if (emit_col == 0) nb[k][0] = '0;
      if (emit_col + 1 >= w) nb[k][2] = '0;
      if (emit_row == 0) nb[0][k] = '0;
      if (emit_row + 1 >= h) nb[2][k] = '0;
    end
    acc = 0;
    for (int r = 0; r < 3; r++) begin
      for (int c = 0; c < 3; c++) begin
        wt  = coef_rows[r][c*COEF_BITS +: COEF_BITS];
        acc += longint'(wt) * longint'(nb[r][c]);
      end
    end
    e.sum   = acc[27:0];
    e.row   = emit_row[9:0];
    e.col   = emit_col[9:0];
    e.tlast = (emit_row + 1 >= h) && (emit_col + 1 >= w);
    expected_sums.push_back(e);
    if (e.tlast) begin
      in_row   = 0;
      in_col   = 0;
      emit_row = 0;
      emit_col = 0;
    end else begin
      emit_col++;
    end
  endfunction

  function void check_sum_beat(logic [47:0] d, logic lst);
    conv_sum_t got, e;
    got.sum   = d[27:0];
    got.row   = d[37:28];
    got.col   = d[47:38];
    got.tlast = lst;
    if (expected_sums.size() == 0) begin
      errors++;
      if (errors <= 10)
        $display("result beat with nothing pending: sum %0d row %0d col %0d last %0b",
                 $signed(got.sum), got.row, got.col, got.tlast);
      return;
    end
    e = expected_sums.pop_front();
    if (got.sum !== e.sum || got.row !== e.row || got.col !== e.col ||
        got.tlast !== e.tlast) begin
      errors++;
      if (errors <= 10)
        $display("mismatch: expected sum %0d row %0d col %0d last %0b,",
                 $signed(e.sum), e.row, e.col, e.tlast,
                 " got sum %0d row %0d col %0d last %0b",
                 $signed(got.sum), got.row, got.col, got.tlast);
    end
  endfunction

  function void flag_leftovers();
    if (expected_sums.size() != 0) begin
      $display("%0d expected sums never arrived", expected_sums.size());
      errors += expected_sums.size();
    end
  endfunction
endclass

module conv3x3_zero_pad_filter_core_tb;

  localparam logic                 FUNC_PIXEL = 1'b0;
  localparam logic                 FUNC_FLUSH = 1'b1;
  localparam logic [CFG_IDX_W-1:0] REG_NONE   = 3'd7;  // decodes to no register

  logic             clk;
  logic             rst_n;
  logic             in_tvalid;
  logic             in_tready;
  logic [7:0]       in_tdata;   // [7:0] pixel
  logic             in_tuser;   // [0] func
  logic             out_tvalid;
  logic             out_tready;
  logic [47:0]      out_tdata;  // [27:0] sum, [37:28] out_row, [47:38] out_col
  logic             out_tlast;
  logic             cfg_we;
  logic [CFG_IDX_W-1:0] cfg_index;
  logic [CFG_W-1:0] cfg_wdata;

  conv_checker sb;
  int          beats_sent = 0;
  bit          calm = 1'b0;
  bit          hold_req = 1'b0;
  bit          hold_done = 1'b0;

  conv3x3_zero_pad_filter_core u_top (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tlast  (out_tlast),
    .cfg_we     (cfg_we),
    .cfg_index  (cfg_index),
    .cfg_wdata  (cfg_wdata)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  always @(posedge clk) begin
    if (rst_n) begin
      if (in_tvalid && in_tready) sb.add_pixel_beat(in_tuser, in_tdata);
      if (out_tvalid && out_tready) sb.check_sum_beat(out_tdata, out_tlast);
    end
  end

  // Result side: random back-pressure, one long hold-off while the sender
  // keeps offering beats so that the pipeline backs up into the input.
  initial begin
    out_tready = 1'b0;
    @(posedge rst_n);
    forever begin
      @(negedge clk);
      if (hold_req && !hold_done) begin
        hold_done = 1'b1;
        out_tready <= 1'b0;
        repeat (400) @(negedge clk);
      end
      out_tready <= calm || ($urandom_range(99) >= 38);
    end
  end

  initial begin
    #2_000_000;
    $display("conv3x3_zero_pad_filter_core verification failed");
    $finish;
  end

  function automatic logic [CFG_W-1:0] pick_coefs();
    logic [63:0] t;
    t = {$urandom, $urandom};
    case ($urandom_range(7))
      0: t[47:0] = {3{16'h8000}};
      1: t[47:0] = {3{16'h7FFF}};
      2: t[47:0] = {16'h0001, 16'hFFFF, 16'h0002};
      default: ;
    endcase
    return t[47:0];
  endfunction

  // Size registers take only the low bits; junk above them must be ignored.
  function automatic logic [CFG_W-1:0] dim_word(int v);
    logic [63:0] t;
    t = {$urandom, $urandom};
    if ($urandom_range(1) == 0) t = '0;
    return {t[CFG_W-1:DIM_W], v[DIM_W-1:0]};
  endfunction

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_W-1:0] val);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= val;
    sb.set_reg(idx, val);
    @(negedge clk);
    cfg_we <= 1'b0;
    @(negedge clk);
  endtask

  task automatic send_beat(input logic fl, input pix_t px);
    while (!calm && $urandom_range(99) < 38) begin
      in_tvalid <= 1'b0;
      @(negedge clk);
    end
    in_tvalid <= 1'b1;
    in_tuser  <= fl;
    in_tdata  <= px;
    @(posedge clk);
    while (!in_tready) @(posedge clk);
    @(negedge clk);
    beats_sent++;
    calm = (beats_sent >= 500 && beats_sent < 800);
    if (beats_sent == 300) hold_req = 1'b1;
  endtask

  // One whole frame: W*H frame beats, some of them flush ticks, then W+1 beats to drain the window.
  task automatic run_frame();
    int   w, h, r;
    pix_t px;
    w = sb.eff_width();
    h = sb.eff_height();
    repeat (w * h) begin
      r  = $urandom_range(99);
      px = pix_t'($urandom_range(255));
      if (r < 6) px = '0;
      else if (r < 12) px = 8'hFF;
      send_beat((r >= 92) ? FUNC_FLUSH : FUNC_PIXEL, px);
    end
    repeat (w + 1)
      send_beat(($urandom_range(99) < 75) ? FUNC_FLUSH : FUNC_PIXEL,
                pix_t'($urandom_range(255)));
  endtask

  task automatic settle();
    in_tvalid <= 1'b0;
    while (sb.pending() != 0) @(negedge clk);
    repeat (8) @(negedge clk);
  endtask

  initial begin
    int w, h, guard;
    sb        = new();
    rst_n     = 1'b0;
    in_tvalid = 1'b0;
    in_tdata  = '0;
    in_tuser  = 1'b0;
    cfg_we    = 1'b0;
    cfg_index = '0;
    cfg_wdata = '0;
    repeat (12) @(negedge clk);
    rst_n <= 1'b1;

    // Reset kernel (identity) on a 4x2 frame, with a flush inside the frame
    // and pixel beats among the drain beats.
    write_reg(REG_NONE, {$urandom, 16'hFFFF});
    write_reg(REG_WIDTH, 48'd4);
    write_reg(REG_HEIGHT, 48'd2);
    send_beat(FUNC_PIXEL, 8'd0);
    send_beat(FUNC_PIXEL, 8'd255);
    send_beat(FUNC_PIXEL, 8'd1);
    send_beat(FUNC_PIXEL, 8'd128);
    send_beat(FUNC_PIXEL, 8'd255);
    send_beat(FUNC_PIXEL, 8'd0);
    send_beat(FUNC_FLUSH, 8'hFF);
    send_beat(FUNC_PIXEL, 8'd255);
    send_beat(FUNC_FLUSH, 8'h00);
    send_beat(FUNC_PIXEL, 8'hAA);
    send_beat(FUNC_FLUSH, 8'h55);
    send_beat(FUNC_PIXEL, 8'hFF);
    send_beat(FUNC_FLUSH, 8'h00);
    settle();

    // Most negative sum: every weight at its minimum over a full 3x3 of 255.
    write_reg(REG_COEF_TOP, {3{16'h8000}});
    write_reg(REG_COEF_MID, {3{16'h8000}});
    write_reg(REG_COEF_BOT, {3{16'h8000}});
    write_reg(REG_WIDTH, 48'd3);
    write_reg(REG_HEIGHT, 48'd3);
    repeat (9) send_beat(FUNC_PIXEL, 8'hFF);
    repeat (4) send_beat(FUNC_FLUSH, 8'h00);
    settle();

    // Zero sizes saturate to a single pixel.
    write_reg(REG_COEF_MID, {3{16'h7FFF}});
    write_reg(REG_WIDTH, 48'd0);
    write_reg(REG_HEIGHT, 48'd0);
    send_beat(FUNC_PIXEL, 8'hFF);
    send_beat(FUNC_FLUSH, 8'h00);
    send_beat(FUNC_FLUSH, 8'h00);
    settle();

    while (beats_sent < 320) begin
      if ($urandom_range(3) != 0) write_reg(REG_COEF_TOP, pick_coefs());
      if ($urandom_range(3) != 0) write_reg(REG_COEF_MID, pick_coefs());
      if ($urandom_range(3) != 0) write_reg(REG_COEF_BOT, pick_coefs());
      if ($urandom_range(3) != 0) begin
        case ($urandom_range(9))
          0: w = 0;
          1: w = 1;
          2: w = $urandom_range(13, 40);
          default: w = $urandom_range(2, 12);
        endcase
        write_reg(REG_WIDTH, dim_word(w));
      end
      if ($urandom_range(3) != 0) begin
        case ($urandom_range(9))
          0: h = 0;
          1: h = 1;
          2: h = $urandom_range(9, 24);
          default: h = $urandom_range(2, 8);
        endcase
        write_reg(REG_HEIGHT, dim_word(h));
      end
      repeat ($urandom_range(1, 3)) run_frame();
      settle();
    end

    // Oversized height register: the frame height saturates to its maximum.
    write_reg(REG_COEF_TOP, pick_coefs());
    write_reg(REG_COEF_MID, pick_coefs());
    write_reg(REG_COEF_BOT, pick_coefs());
    write_reg(REG_WIDTH, 48'd1);
    write_reg(REG_HEIGHT, 48'h7FF);
    run_frame();
    in_tvalid <= 1'b0;

    guard = 0;
    while (sb.pending() != 0 && guard < 20000) begin
      @(negedge clk);
      guard++;
    end
    repeat (10) @(negedge clk);
    sb.flag_leftovers();
    if (sb.errors == 0)
      $display("conv3x3_zero_pad_filter_core verification clean");
    else
      $display("conv3x3_zero_pad_filter_core verification failed");
    $finish;
  end

endmodule
